/* rtl/czs_pkg.sv */
// shared types and constants for the column z-score standardizer
package czs_pkg;

    localparam int CNT_W = 7;
    localparam int SUM_W = 30;
    localparam int SQ_W  = 54;
    localparam int X_W   = 24;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_VAR,
        ST_SHIFT,
        ST_SQRT,
        ST_READ,
        ST_PROD,
        ST_NUM,
        ST_DIV,
        ST_OUT
    } t_state;

    // column summary handed from the loader to the emitter
    typedef struct packed {
        logic [CNT_W-1:0]        cnt;
        logic [CNT_W-1:0]        n;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
    } t_col;

endpackage

/* rtl/czs_front.sv */
// loader: accepts samples, fills the sample store and keeps the column sums
module czs_front import czs_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [X_W-1:0]   i_sample,
    input  logic                    i_missing,
    input  logic                    i_last,
    input  logic                    i_back_busy,
    input  logic                    i_take,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [X_W:0]            o_rd_data,
    output t_col                    o_col,
    output logic                    o_col_valid,
    output logic                    o_busy
);
    localparam int AW = $clog2(DEPTH);

    logic [X_W:0]            r_mem [DEPTH];
    logic [CNT_W-1:0]        r_cnt;
    logic [CNT_W-1:0]        r_n;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]         r_sq;
    logic                    r_full;
    logic                    w_acc;
    logic                    w_end;
    logic signed [2*X_W-1:0] w_sqr;

    assign o_busy = r_full | i_back_busy;
    assign w_acc  = i_start & ~o_busy;
    assign w_end  = i_last | (r_cnt == CNT_W'(DEPTH - 1));
    assign w_sqr  = i_sample * i_sample;

    // sample store, one write per transfer, registered read for the emitter
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mem[r_cnt[AW-1:0]] <= {i_missing, i_sample};
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

    // counts and running sums, cleared when the emitter takes the column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_n    <= '0;
            r_sum  <= '0;
            r_sq   <= '0;
            r_full <= 1'b0;
        end else if (i_take) begin
            r_cnt  <= '0;
            r_n    <= '0;
            r_sum  <= '0;
            r_sq   <= '0;
            r_full <= 1'b0;
        end else if (w_acc) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (!i_missing) begin
                r_n   <= r_n + CNT_W'(1);
                r_sum <= r_sum + SUM_W'(i_sample);
                r_sq  <= r_sq + SQ_W'($unsigned(w_sqr));
            end
            r_full <= w_end;
        end
    end

    assign o_col_valid = r_full;
    assign o_col.cnt   = r_cnt;
    assign o_col.n     = r_n;
    assign o_col.sum   = r_sum;
    assign o_col.sq    = r_sq;

endmodule

/* rtl/czs_back.sv */
// emitter: variance, square root and per-sample division, one result at a time
module czs_back import czs_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_col                     i_col,
    input  logic                     i_col_valid,
    input  logic [X_W:0]             i_rd_data,
    output logic [$clog2(DEPTH)-1:0] o_rd_addr,
    output logic                     o_take,
    output logic                     o_busy,
    output logic                     o_valid,
    output logic signed [X_W-1:0]    o_zscore,
    output logic                     o_missing_out,
    output logic                     o_last_out
);
    localparam int AW = $clog2(DEPTH);

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, r_n, r_k;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]         r_sq;
    logic [60:0]             r_nq;
    logic signed [59:0]      r_ss;
    logic [61:0]             r_v;
    logic [4:0]              r_s;
    logic                    r_scale;
    logic [62:0]             r_sv, r_sr, r_bit;
    logic [31:0]             r_den;
    logic signed [31:0]      r_prod;
    logic                    r_neg;
    logic [63:0]             r_qn;
    logic [31:0]             r_rm;
    logic [5:0]              r_dc;
    logic                    r_valid;
    logic [X_W-1:0]          r_z;
    logic                    r_mo, r_lo;

    logic signed [61:0]      w_var;
    logic                    w_big;
    logic [62:0]             w_t, w_nv, w_nr;
    logic signed [X_W-1:0]   w_x;
    logic                    w_m;
    logic signed [27:0]      w_x16;
    logic [X_W-1:0]          w_xsat;
    logic signed [32:0]      w_d;
    logic [32:0]             w_mag;
    logic [63:0]             w_num;
    logic [31:0]             w_tr;
    logic                    w_ge;
    logic [X_W-1:0]          w_qsat;
    logic                    w_lastk;

    assign o_take    = i_col_valid & (r_state == ST_IDLE);
    assign o_busy    = (r_state != ST_IDLE);
    assign o_rd_addr = r_k[AW-1:0];
    assign w_lastk   = (r_k + CNT_W'(1) == r_cnt);

    // n^2 times the variance, and the normalizing shift test
    assign w_var = $signed({1'b0, r_nq}) - $signed({2'b0, r_ss});
    assign w_big = ((r_v >> (6'd62 - {r_s, 1'b0})) != '0);

    // one digit step of the square root
    always_comb begin
        w_t  = r_sr + r_bit;
        w_nv = r_sv;
        w_nr = r_sr >> 1;
        if (r_sv >= w_t) begin
            w_nv = r_sv - w_t;
            w_nr = (r_sr >> 1) + r_bit;
        end
    end

    // stored entry, and the pass-through value times 16, saturated
    assign w_m    = i_rd_data[X_W];
    assign w_x    = $signed(i_rd_data[X_W-1:0]);
    assign w_x16  = {w_x, 4'b0000};
    assign w_xsat = (w_x16 > 28'sd8388607)  ? 24'h7FFFFF :
                    (w_x16 < -28'sd8388608) ? 24'h800000 : w_x16[X_W-1:0];

    // numerator with rounding offset
    assign w_d   = $signed({r_prod[31], r_prod}) - $signed({{3{r_sum[SUM_W-1]}}, r_sum});
    assign w_mag = w_d[32] ? 33'(-w_d) : 33'(w_d);
    assign w_num = ({31'd0, w_mag} << (6'd16 + {1'b0, r_s})) + {33'd0, r_den[31:1]};

    // restoring divider step
    assign w_tr = {r_rm[30:0], r_qn[63]};
    assign w_ge = (w_tr >= r_den);

    // saturated signed quotient
    always_comb begin
        if (!r_neg) begin
            w_qsat = (r_qn > 64'd8388607) ? 24'h7FFFFF : r_qn[X_W-1:0];
        end else begin
            w_qsat = (r_qn > 64'd8388608) ? 24'h800000 : X_W'(~r_qn[X_W-1:0] + 24'd1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_col_valid) n_state = ST_MUL;
            ST_MUL:   n_state = ST_VAR;
            ST_VAR:   n_state = (w_var[61] || w_var == '0) ? ST_READ : ST_SHIFT;
            ST_SHIFT: if (!w_big) n_state = ST_SQRT;
            ST_SQRT:  if (r_bit[0]) n_state = ST_READ;
            ST_READ:  n_state = ST_PROD;
            ST_PROD: begin
                if (r_scale && !w_m) n_state = ST_NUM;
                else n_state = w_lastk ? ST_IDLE : ST_READ;
            end
            ST_NUM:   n_state = ST_DIV;
            ST_DIV:   if (r_dc == 6'd63) n_state = ST_OUT;
            ST_OUT:   n_state = w_lastk ? ST_IDLE : ST_READ;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_OUT) ||
                       (r_state == ST_PROD && !(r_scale && !w_m));
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cnt <= i_col.cnt;
                r_n   <= i_col.n;
                r_sum <= i_col.sum;
                r_sq  <= i_col.sq;
                r_k   <= '0;
            end
            ST_MUL: begin
                r_nq <= 61'(r_n) * 61'(r_sq);
                r_ss <= r_sum * r_sum;
            end
            ST_VAR: begin
                r_scale <= !(w_var[61] || w_var == '0);
                r_v     <= w_var;
                r_s     <= 5'd16;
            end
            ST_SHIFT: begin
                if (w_big) begin
                    r_s <= r_s - 5'd1;
                end else begin
                    r_sv  <= {1'b0, r_v} << {r_s, 1'b0};
                    r_sr  <= '0;
                    r_bit <= 63'd1 << 62;
                end
            end
            ST_SQRT: begin
                r_sv  <= w_nv;
                r_sr  <= w_nr;
                r_bit <= r_bit >> 2;
                r_den <= (w_nr == '0) ? 32'd1 : w_nr[31:0];
            end
            ST_PROD: begin
                r_prod <= $signed({1'b0, r_n}) * w_x;
                r_mo   <= w_m;
                r_lo   <= w_lastk;
                r_z    <= w_m ? '0 : w_xsat;
                if (!(r_scale && !w_m)) r_k <= r_k + CNT_W'(1);
            end
            ST_NUM: begin
                r_neg <= w_d[32];
                r_qn  <= w_num;
                r_rm  <= '0;
                r_dc  <= '0;
            end
            ST_DIV: begin
                r_rm <= w_ge ? (w_tr - r_den) : w_tr;
                r_qn <= {r_qn[62:0], w_ge};
                r_dc <= r_dc + 6'd1;
            end
            ST_OUT: begin
                r_z <= w_qsat;
                r_k <= r_k + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_valid       = r_valid;
    assign o_zscore      = r_z;
    assign o_missing_out = r_mo;
    assign o_last_out    = r_lo;

    // a result only follows a sample step or a finished division
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($past(r_state) == ST_PROD || $past(r_state) == ST_OUT))
        else $error("result strobe without a sample step");

    // a missing sample always comes out as zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_mo) |-> (r_z == '0))
        else $error("missing sample with nonzero value");

    // the square root leads straight into emission
    a_sqrt_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT) |=> (r_state == ST_SQRT || r_state == ST_READ))
        else $error("square root left to a wrong state");

endmodule

/* rtl/column_zscore_standardizer.sv */
// top level of the column z-score standardizer
// Samples load at one per cycle while busy is low; a column ends on last or when
// DEPTH samples are stored. Busy then stays high until every result has gone out.
// Setup after column end covers handoff, products and the variance check; a scaled
// column adds the shift search and the square root. Each result then passes a read
// and a sample step; a scaled sample that is not missing adds numerator setup,
// the one-bit-per-cycle divider and an output step. Results are strobed by o_valid
// for one cycle and must be taken then: the receiver cannot stall.
module column_zscore_standardizer import czs_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [X_W-1:0] i_sample,
    input  logic                  i_missing,
    input  logic                  i_last,
    output logic                  o_valid,
    output logic signed [X_W-1:0] o_zscore,
    output logic                  o_missing_out,
    output logic                  o_last_out
);
    localparam int AW = $clog2(DEPTH);

    t_col            w_col;
    logic            w_col_valid;
    logic            w_take;
    logic            w_back_busy;
    logic [AW-1:0]   w_rd_addr;
    logic [X_W:0]    w_rd_data;

    // loader and sample store
    czs_front #(.DEPTH(DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_sample    (i_sample),
        .i_missing   (i_missing),
        .i_last      (i_last),
        .i_back_busy (w_back_busy),
        .i_take      (w_take),
        .i_rd_addr   (w_rd_addr),
        .o_rd_data   (w_rd_data),
        .o_col       (w_col),
        .o_col_valid (w_col_valid),
        .o_busy      (busy)
    );

    // statistics and result emission
    czs_back #(.DEPTH(DEPTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_col         (w_col),
        .i_col_valid   (w_col_valid),
        .i_rd_data     (w_rd_data),
        .o_rd_addr     (w_rd_addr),
        .o_take        (w_take),
        .o_busy        (w_back_busy),
        .o_valid       (o_valid),
        .o_zscore      (o_zscore),
        .o_missing_out (o_missing_out),
        .o_last_out    (o_last_out)
    );

endmodule
